### hdl/largest_component_size_macros.svh
// Assertion macros used by the RTL of the component-size block.
`ifndef LARGEST_COMPONENT_SIZE_MACROS_SVH
`define LARGEST_COMPONENT_SIZE_MACROS_SVH

`ifndef SYNTHESIS
`define LCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LCS_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LCS_ASSERT(label, prop, msg)
`define LCS_NEVER(label, expr, msg)
`endif

`endif

### hdl/lcs_pkg.sv
package lcs_pkg;

  localparam int ROW_W  = 64;
  localparam int IDX_W  = 6;
  localparam int SIZE_W = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_MERGE
  } lcs_state_t;

endpackage

### hdl/lcs_ram.sv
module lcs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/lcs_lowbit.sv
module lcs_lowbit #(
  parameter int W = 64
) (
  input  logic [W-1:0]         vec,
  output logic [W-1:0]         onehot,
  output logic [$clog2(W)-1:0] idx,
  output logic                 any
);

  localparam int IW = $clog2(W);

  always_comb begin
    onehot = vec & (~vec + W'(1));
    idx    = '0;
    for (int i = 0; i < W; i++) begin
      if (onehot[i]) begin
        idx = idx | IW'(i);
      end
    end
    any = |vec;
  end

endmodule

### hdl/largest_component_size.sv
// In-range rows are stored on accept; start is accepted whenever busy is low.
// A request with last_row set starts the component walk: a pick step per new
// component, a pick and a merge step per node (row memory read, then merge)
// and a final pick; done pulses in the first cycle with busy low.
// The receiver cannot stall. Synchronous reset clears the control state and
// the row valid bits, so every stored row reads as zero until it is written.
module largest_component_size
  import lcs_pkg::*;
#(
  parameter int NODES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [IDX_W-1:0]  row_index,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic              last_row,
  output logic              done,
  output logic [SIZE_W-1:0] largest_size
);

  `include "largest_component_size_macros.svh"

  localparam int AW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  lcs_state_t state, state_next;
  logic [NODES-1:0] assigned, assigned_next;
  logic [NODES-1:0] pending, pending_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    best, best_next;
  logic [AW-1:0]    cur_node, cur_node_next;
  logic [NODES-1:0] row_valid, row_valid_next;
  logic             done_next;
  logic [SIZE_W-1:0] largest_size_next;

  logic             accept;
  logic             in_range;
  logic             we;
  logic [AW-1:0]    raddr;
  logic [NODES-1:0] rdata;
  logic [NODES-1:0] row;
  logic [NODES-1:0] reach;
  logic [NODES-1:0] search_vec;
  logic [NODES-1:0] low_onehot;
  logic [AW-1:0]    low_idx;
  logic             low_any;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, row_index} < (IDX_W + 1)'(NODES));
  assign we       = accept && in_range;

  lcs_ram #(
    .WIDTH(NODES),
    .DEPTH(NODES)
  ) u_rows (
    .clk  (clk),
    .we   (we),
    .waddr(row_index[AW-1:0]),
    .wdata(row_bits[NODES-1:0]),
    .raddr(raddr),
    .rdata(rdata)
  );

  // One lowest-bit finder serves both the node queue and the start search.
  assign search_vec = (pending != '0) ? pending : ~assigned;

  lcs_lowbit #(
    .W(NODES)
  ) u_lowbit (
    .vec   (search_vec),
    .onehot(low_onehot),
    .idx   (low_idx),
    .any   (low_any)
  );

  assign row   = row_valid[cur_node] ? rdata : '0;
  assign reach = row & ~assigned;
  assign raddr = low_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      row_valid <= '0;
    end else begin
      state     <= state_next;
      done      <= done_next;
      row_valid <= row_valid_next;
    end
    assigned     <= assigned_next;
    pending      <= pending_next;
    count        <= count_next;
    best         <= best_next;
    cur_node     <= cur_node_next;
    largest_size <= largest_size_next;
  end

  always_comb begin
    state_next        = state;
    assigned_next     = assigned;
    pending_next      = pending;
    count_next        = count;
    best_next         = best;
    cur_node_next     = cur_node;
    row_valid_next    = row_valid;
    done_next         = 1'b0;
    largest_size_next = largest_size;
    unique case (state)
      ST_IDLE: begin
        if (we) begin
          row_valid_next[row_index[AW-1:0]] = 1'b1;
        end
        if (accept && last_row) begin
          assigned_next = '0;
          pending_next  = '0;
          count_next    = '0;
          best_next     = '0;
          state_next    = ST_PICK;
        end
      end
      ST_PICK: begin
        if (pending != '0) begin
          cur_node_next = low_idx;
          pending_next  = pending & ~low_onehot;
          count_next    = count + CW'(1);
          state_next    = ST_MERGE;
        end else begin
          best_next = (count > best) ? count : best;
          if (low_any) begin
            assigned_next = assigned | low_onehot;
            pending_next  = low_onehot;
            count_next    = '0;
          end else begin
            done_next         = 1'b1;
            largest_size_next = SIZE_W'(best_next);
            state_next        = ST_IDLE;
          end
        end
      end
      ST_MERGE: begin
        assigned_next = assigned | reach;
        pending_next  = pending | reach;
        state_next    = ST_PICK;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `LCS_ASSERT(a_done_after_pick, done |-> $past(state) == ST_PICK, "result without final pick")
  `LCS_ASSERT(a_pending_assigned, busy |-> ((pending & ~assigned) == '0), "queue unassigned")
  `LCS_NEVER(a_size_nonzero, done && (largest_size == '0), "largest size of zero reported")
  `LCS_ASSERT(a_last_goes_busy, (accept && last_row) |=> busy, "walk not started")

endmodule
